@@ rtl/tmcg_pkg.sv @@
// Shared types and constants for the text mode character generator.
// No dependencies; tmcg_fetch and the top level take names from here by scope.
`default_nettype none

package tmcg_pkg;

    // Item kinds, carried on the input tuser.
    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_FETCH  = 2'd2,
        CMD_RENDER = 2'd3
    } t_cmd;

    // Configuration register indexes.
    localparam logic [2:0] CFG_COL80      = 3'd0;
    localparam logic [2:0] CFG_PAGE2      = 3'd1;
    localparam logic [2:0] CFG_AUX_READ   = 3'd2;
    localparam logic [2:0] CFG_GLYPHS     = 3'd3;
    localparam logic [2:0] CFG_FLASH_PER  = 3'd4;

    localparam int unsigned GLYPH_BYTES_DEF = 1024;
    localparam int unsigned CELL_LINES      = 8;
    localparam logic [7:0]  FLASH_PER_RST   = 8'd16;

    localparam logic [11:0] PAGE1_BASE = 12'h400;
    localparam logic [11:0] PAGE2_BASE = 12'h800;
    localparam logic [11:0] LINE_STEP  = 12'h080;
    localparam logic [11:0] BLOCK_STEP = 12'h028;

    localparam logic [7:0] TOP_MASK    = 8'hC0;
    localparam logic [7:0] TOP_FLASH   = 8'h40;
    localparam logic [7:0] IDX6_MASK   = 8'h3F;
    localparam logic [7:0] IDX7_MASK   = 8'h7F;
    localparam logic [6:0] SOLID_PIX   = 7'h7F;

    typedef struct packed {
        logic       wide_text;
        logic       page2_select;
        logic       aux_bank_read;
        logic       glyphs_loaded;
        logic [7:0] flash_period;
    } t_cfg;

    // Item in flight between the memory read and the output register.
    typedef struct packed {
        t_cmd        cmd;
        logic [11:0] mem_address;
        logic        aux_bank;
        logic        invert;
        logic        solid_fill;
        logic        flash_phase;
    } t_stage;

endpackage

`default_nettype wire

@@ rtl/tmcg_glyph_ram.sv @@
// Glyph store: single write port, single registered read port.
// Depends on nothing outside this file.
`default_nettype none

module tmcg_glyph_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/tmcg_flash.sv @@
// Frame counter and flash phase, advanced by frame tick items.
// Depends on nothing outside this file.
`default_nettype none

module tmcg_flash (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_tick,
    input  wire logic [7:0]  i_period,
    output logic             o_phase,
    output logic             o_phase_next
);

    logic [7:0] r_count, n_count;
    logic       r_phase, n_phase;
    logic [8:0] w_inc;

    always_comb begin
        w_inc   = {1'b0, r_count} + 9'd1;
        n_count = r_count;
        n_phase = r_phase;
        if (i_tick) begin
            // The compare is done one bit wider so a lowered period still wraps.
            if (w_inc >= {1'b0, i_period}) begin
                n_count = '0;
                n_phase = ~r_phase;
            end else begin
                n_count = w_inc[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_phase <= 1'b0;
        end else begin
            r_count <= n_count;
            r_phase <= n_phase;
        end
    end

    assign o_phase      = r_phase;
    assign o_phase_next = n_phase;

endmodule

`default_nettype wire

@@ rtl/tmcg_fetch.sv @@
// Text screen address and bank for a row and column, 40 or 80 columns.
// Depends on tmcg_pkg for constants and the configuration record.
`default_nettype none

module tmcg_fetch (
    input  wire tmcg_pkg::t_cfg i_cfg,
    input  wire logic [4:0]     i_row,
    input  wire logic [6:0]     i_col,
    output logic      [11:0]    o_addr,
    output logic                o_bank
);

    logic [11:0] w_base;
    logic [11:0] w_row_off;
    logic [11:0] w_col_part;

    always_comb begin
        // Rows interleave in groups of eight: line within group, then group.
        w_row_off = (12'(i_row[2:0]) * tmcg_pkg::LINE_STEP)
                  + (12'(i_row[4:3]) * tmcg_pkg::BLOCK_STEP);
        if (i_cfg.wide_text) begin
            w_base     = tmcg_pkg::PAGE1_BASE;
            w_col_part = 12'(i_col[6:1]);
            o_bank     = ~i_col[0];
        end else begin
            w_base     = i_cfg.page2_select ? tmcg_pkg::PAGE2_BASE : tmcg_pkg::PAGE1_BASE;
            w_col_part = 12'(i_col);
            o_bank     = i_cfg.aux_bank_read;
        end
        o_addr = w_base + w_row_off + w_col_part;
    end

endmodule

`default_nettype wire

@@ rtl/text_mode_character_generator_unit.sv @@
// Top level of the text mode character generator.
// Depends on tmcg_pkg, tmcg_glyph_ram, tmcg_flash and tmcg_fetch.
//
// Usage: items arrive on the s_axis channel, the kind in tuser (load glyph
// byte, frame tick, fetch address, render line) and the fields in tdata.
// Every item gives exactly one result item on the m_axis channel, in order.
// Configuration registers are written on the i_cfg channel, which is always
// ready; they should be written only while no item is in flight.
//
// The glyph store is read at the edge that accepts an item; the middle stage
// then moves the item into the output register once that register is free,
// and the result waits there until the receiver takes it. Throughput is one
// item per clock while the receiver does not stall; an item makes at most
// one access to the glyph store, so items follow back to back.
// A load writes the store at its acceptance, so a render of the same byte
// in the next cycle already reads the new value.
//
// When the receiver stalls, the output register and the stage behind it
// hold their items and the input keeps accepting until both are full.
// Synchronous reset empties the pipeline, clears the frame counter and the
// flash phase, and returns the registers to their defaults (flash period 16).
// The glyph store is not cleared: it must be loaded before glyphs are used.
`default_nettype none

module text_mode_character_generator_unit #(
    parameter int unsigned GLYPH_BYTES = tmcg_pkg::GLYPH_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input items.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata from bit 0: glyph_addr[9:0], glyph_data[17:10], text_row[22:18],
    // text_col[29:23], char_code[37:30], glyph_line[40:38], zero [47:41].
    input  wire logic [47:0] s_axis_tdata,
    // tuser: cmd[1:0].
    input  wire logic [1:0]  s_axis_tuser,
    // Result items.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata from bit 0: mem_address[11:0], aux_bank[12], pixel_bits[19:13],
    // solid_fill[20], flash_phase_out[21], zero [23:22].
    output logic      [23:0] m_axis_tdata,
    // Configuration writes.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    localparam int unsigned AW = $clog2(GLYPH_BYTES);

    // Input field unpacking.
    logic [9:0] w_glyph_addr;
    logic [7:0] w_glyph_data;
    logic [4:0] w_text_row;
    logic [6:0] w_text_col;
    logic [7:0] w_char_code;
    logic [2:0] w_glyph_line;
    tmcg_pkg::t_cmd w_cmd;

    assign w_glyph_addr = s_axis_tdata[9:0];
    assign w_glyph_data = s_axis_tdata[17:10];
    assign w_text_row   = s_axis_tdata[22:18];
    assign w_text_col   = s_axis_tdata[29:23];
    assign w_char_code  = s_axis_tdata[37:30];
    assign w_glyph_line = s_axis_tdata[40:38];
    assign w_cmd        = tmcg_pkg::t_cmd'(s_axis_tuser);

    // Configuration registers.
    tmcg_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wide_text     <= 1'b0;
            r_cfg.page2_select  <= 1'b0;
            r_cfg.aux_bank_read <= 1'b0;
            r_cfg.glyphs_loaded <= 1'b0;
            r_cfg.flash_period  <= tmcg_pkg::FLASH_PER_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tmcg_pkg::CFG_COL80:     r_cfg.wide_text     <= i_cfg_data[0];
                tmcg_pkg::CFG_PAGE2:     r_cfg.page2_select  <= i_cfg_data[0];
                tmcg_pkg::CFG_AUX_READ:  r_cfg.aux_bank_read <= i_cfg_data[0];
                tmcg_pkg::CFG_GLYPHS:    r_cfg.glyphs_loaded <= i_cfg_data[0];
                tmcg_pkg::CFG_FLASH_PER: r_cfg.flash_period  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline handshake: the middle stage moves on whenever the output
    // register is empty or being emptied.
    logic           r_s1_valid;
    tmcg_pkg::t_stage r_s1;
    logic           r_out_valid;
    logic [23:0]    r_out_data;
    logic           w_out_free;
    logic           w_s1_move;
    logic           w_accept;

    assign w_out_free    = ~r_out_valid | m_axis_tready;
    assign w_s1_move     = r_s1_valid & w_out_free;
    assign s_axis_tready = ~r_s1_valid | w_out_free;
    assign w_accept      = s_axis_tvalid & s_axis_tready;

    // Flash phase; a tick takes effect at its acceptance.
    logic w_phase;
    logic w_phase_next;

    tmcg_flash u_flash (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (w_accept && (w_cmd == tmcg_pkg::CMD_TICK)),
        .i_period     (r_cfg.flash_period),
        .o_phase      (w_phase),
        .o_phase_next (w_phase_next)
    );

    // Fetch address.
    logic [11:0] w_fetch_addr;
    logic        w_fetch_bank;

    tmcg_fetch u_fetch (
        .i_cfg  (r_cfg),
        .i_row  (w_text_row),
        .i_col  (w_text_col),
        .o_addr (w_fetch_addr),
        .o_bank (w_fetch_bank)
    );

    // Render decode and glyph store address.
    logic        w_inverse;
    logic        w_flash;
    logic [7:0]  w_idx;
    logic [11:0] w_raw_addr;
    logic [11:0] w_wrap_addr;
    logic [AW-1:0] w_mem_addr;

    always_comb begin
        w_inverse = (w_char_code & tmcg_pkg::TOP_MASK) == 8'h00;
        w_flash   = (w_char_code & tmcg_pkg::TOP_MASK) == tmcg_pkg::TOP_FLASH;
        w_idx     = w_char_code & ((w_inverse || w_flash) ? tmcg_pkg::IDX6_MASK
                                                          : tmcg_pkg::IDX7_MASK);
        if (w_cmd == tmcg_pkg::CMD_LOAD) begin
            w_raw_addr = 12'(w_glyph_addr);
        end else begin
            w_raw_addr = (12'(w_idx) * 12'(tmcg_pkg::CELL_LINES)) + 12'(w_glyph_line);
        end
        // The raw address stays below 1024, so for a store of 512 bytes or more one
        // conditional subtract gives the wrap.
        if (w_raw_addr >= 12'(GLYPH_BYTES)) begin
            w_wrap_addr = w_raw_addr - 12'(GLYPH_BYTES);
        end else begin
            w_wrap_addr = w_raw_addr;
        end
        w_mem_addr = w_wrap_addr[AW-1:0];
    end

    logic [7:0] w_rdata;

    tmcg_glyph_ram #(
        .DEPTH (GLYPH_BYTES),
        .AW    (AW)
    ) u_glyph_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && (w_cmd == tmcg_pkg::CMD_LOAD)),
        .i_waddr (w_mem_addr),
        .i_wdata (w_glyph_data),
        .i_re    (w_accept && (w_cmd == tmcg_pkg::CMD_RENDER)),
        .i_raddr (w_mem_addr),
        .o_rdata (w_rdata)
    );

    // Middle stage: holds the item while its glyph byte is read.
    tmcg_pkg::t_stage n_s1;

    always_comb begin
        n_s1.cmd         = w_cmd;
        n_s1.mem_address = '0;
        n_s1.aux_bank    = 1'b0;
        n_s1.invert      = 1'b0;
        n_s1.solid_fill  = 1'b0;
        n_s1.flash_phase = w_phase_next;
        case (w_cmd)
            tmcg_pkg::CMD_FETCH: begin
                n_s1.mem_address = w_fetch_addr;
                n_s1.aux_bank    = w_fetch_bank;
            end
            tmcg_pkg::CMD_RENDER: begin
                n_s1.invert     = w_inverse | (w_flash & w_phase);
                n_s1.solid_fill = ~r_cfg.glyphs_loaded;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1 <= n_s1;
        end
    end

    // Output stage: pixels from the glyph byte, then the result register.
    logic [6:0]  w_pix;
    logic [23:0] n_out_data;

    always_comb begin
        w_pix = '0;
        if (r_s1.cmd == tmcg_pkg::CMD_RENDER) begin
            if (r_s1.solid_fill) begin
                w_pix = tmcg_pkg::SOLID_PIX;
            end else begin
                w_pix = w_rdata[6:0] ^ {7{r_s1.invert}};
            end
        end
        n_out_data = {2'b00, r_s1.flash_phase, r_s1.solid_fill, w_pix,
                      r_s1.aux_bank, r_s1.mem_address};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire
